// ===== src/sidc_pkg.sv =====
// Shared types and constants for the signed integer to decimal characters block.
// Used by sidc_cell and signed_int_to_decimal_chars; depends on nothing.
package sidc_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 10;
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0]  DIGIT_BASE = 8'h30;
	localparam logic [CHAR_W-1:0]  MINUS_CODE = 8'h2D;
	localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage

// ===== src/sidc_cell.sv =====
// One decimal digit cell of the conversion chain: shift-add-3 step and digit shift.
// Depends on sidc_pkg.
module sidc_cell (
	input  logic                          clk,
	input  sidc_pkg::cell_op_t            op,
	input  logic                          bit_in,
	input  logic [sidc_pkg::DIGIT_W-1:0]  digit_in,
	output logic                          bit_out,
	output logic [sidc_pkg::DIGIT_W-1:0]  digit
);

	logic [sidc_pkg::DIGIT_W-1:0] digit_q;
	logic [sidc_pkg::DIGIT_W-1:0] adj;

	// add 3 before the shift so the digit never exceeds 9 after doubling
	assign adj     = (digit_q >= sidc_pkg::DABBLE_MIN) ? digit_q + sidc_pkg::DABBLE_ADD : digit_q;
	assign bit_out = adj[sidc_pkg::DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		unique case (op)
			sidc_pkg::CELL_HOLD:   digit_q <= digit_q;
			sidc_pkg::CELL_CLEAR:  digit_q <= '0;
			sidc_pkg::CELL_DABBLE: digit_q <= {adj[sidc_pkg::DIGIT_W-2:0], bit_in};
			sidc_pkg::CELL_SHIFT:  digit_q <= digit_in;
			default:               digit_q <= digit_q;
		endcase
	end

endmodule

// ===== src/signed_int_to_decimal_chars.sv =====
// Top level: signed 32-bit integer to decimal ASCII characters.
// Depends on sidc_pkg and sidc_cell.
//
// Usage:
//   Input channel s_*: one beat carries one signed 32-bit value in s_tdata.
//   Output channel m_*: one beat per character, most significant first; a
//   negative value starts with '-'. m_tlast marks the final digit.
//   The block works on one value at a time; s_tready is high only when idle.
// Conversion:
//   After the input beat, shift-add-3 runs through a chain of ten digit
//   cells, one magnitude bit per cycle. Leading zero digits are then dropped
//   one per cycle (up to nine), the sign is decided, and characters leave
//   at one per cycle while m_tready is high.
//   A new value is accepted only after the final digit has left.
// Reset:
//   arst_n clears the controller to idle; no character is pending afterward.
// Stall:
//   While m_tready is low the current character holds on m_tdata/m_tlast and
//   the digit chain holds; no new value is accepted.
module signed_int_to_decimal_chars (
	input  logic                          clk,
	input  logic                          arst_n,
	// value (bits 31:0, signed)
	input  logic [sidc_pkg::VALUE_W-1:0]  s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// char_code (bits 7:0)
	output logic [sidc_pkg::CHAR_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready
);

	sidc_pkg::state_t state_q, state_d;
	sidc_pkg::cell_op_t cell_op;

	logic [sidc_pkg::VALUE_W-1:0]   mag_q, mag_d;
	logic                           neg_q, neg_d;
	logic [sidc_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
	logic [sidc_pkg::DIG_CNT_W-1:0] dig_cnt_q, dig_cnt_d;

	// chain wiring: index 0 is the least significant cell
	logic                         carry_w [0:sidc_pkg::NUM_DIGITS];
	logic [sidc_pkg::DIGIT_W-1:0] digit_w [0:sidc_pkg::NUM_DIGITS];
	logic [sidc_pkg::DIGIT_W-1:0] top_digit;

	assign carry_w[0] = mag_q[sidc_pkg::VALUE_W-1];
	assign digit_w[0] = '0;

	for (genvar i = 0; i < sidc_pkg::NUM_DIGITS; i++) begin : g_cell
		sidc_cell u_cell (
			.clk      (clk),
			.op       (cell_op),
			.bit_in   (carry_w[i]),
			.digit_in (digit_w[i]),
			.bit_out  (carry_w[i+1]),
			.digit    (digit_w[i+1])
		);
	end

	assign top_digit = digit_w[sidc_pkg::NUM_DIGITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sidc_pkg::ST_IDLE;
			neg_q     <= 1'b0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			neg_q     <= neg_d;
			bit_cnt_q <= bit_cnt_d;
			dig_cnt_q <= dig_cnt_d;
		end
	end

	// magnitude is payload: no reset
	always_ff @(posedge clk) begin
		mag_q <= mag_d;
	end

	always_comb begin
		state_d   = state_q;
		mag_d     = mag_q;
		neg_d     = neg_q;
		bit_cnt_d = bit_cnt_q;
		dig_cnt_d = dig_cnt_q;
		cell_op   = sidc_pkg::CELL_HOLD;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		m_tdata   = sidc_pkg::DIGIT_BASE + {{(sidc_pkg::CHAR_W-sidc_pkg::DIGIT_W){1'b0}}, top_digit};
		m_tlast   = 1'b0;
		unique case (state_q)
			sidc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					// take the magnitude as unsigned so the most negative value works
					neg_d     = s_tdata[sidc_pkg::VALUE_W-1];
					mag_d     = s_tdata[sidc_pkg::VALUE_W-1] ?
					            sidc_pkg::VALUE_W'(~s_tdata + 1'b1) : s_tdata;
					bit_cnt_d = '0;
					cell_op   = sidc_pkg::CELL_CLEAR;
					state_d   = sidc_pkg::ST_CONV;
				end
			end
			sidc_pkg::ST_CONV: begin
				// advance one magnitude bit into the chain
				cell_op   = sidc_pkg::CELL_DABBLE;
				mag_d     = {mag_q[sidc_pkg::VALUE_W-2:0], 1'b0};
				bit_cnt_d = bit_cnt_q + 1'b1;
				if (bit_cnt_q == sidc_pkg::BIT_CNT_W'(sidc_pkg::VALUE_W - 1)) begin
					dig_cnt_d = sidc_pkg::DIG_CNT_W'(sidc_pkg::NUM_DIGITS);
					state_d   = sidc_pkg::ST_SKIP;
				end
			end
			sidc_pkg::ST_SKIP: begin
				// drop leading zeros, always keep the last digit
				if (top_digit == '0 && dig_cnt_q != sidc_pkg::DIG_CNT_W'(1)) begin
					cell_op   = sidc_pkg::CELL_SHIFT;
					dig_cnt_d = dig_cnt_q - 1'b1;
				end else begin
					state_d = neg_q ? sidc_pkg::ST_SIGN : sidc_pkg::ST_EMIT;
				end
			end
			sidc_pkg::ST_SIGN: begin
				m_tvalid = 1'b1;
				m_tdata  = sidc_pkg::MINUS_CODE;
				if (m_tready) begin
					state_d = sidc_pkg::ST_EMIT;
				end
			end
			sidc_pkg::ST_EMIT: begin
				m_tvalid = 1'b1;
				m_tlast  = (dig_cnt_q == sidc_pkg::DIG_CNT_W'(1));
				if (m_tready) begin
					if (m_tlast) begin
						state_d = sidc_pkg::ST_IDLE;
					end else begin
						cell_op   = sidc_pkg::CELL_SHIFT;
						dig_cnt_d = dig_cnt_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = sidc_pkg::ST_IDLE;
			end
		endcase
	end

	// the top cell never overflows: any 32-bit magnitude fits in ten digits
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sidc_pkg::ST_CONV |-> !carry_w[sidc_pkg::NUM_DIGITS])
		else $error("digit chain overflow during conversion");

	// an emitted digit is always a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sidc_pkg::ST_EMIT |-> top_digit <= 4'd9)
		else $error("non-decimal digit emitted");

	// digit count never runs out while characters are pending
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sidc_pkg::ST_EMIT || state_q == sidc_pkg::ST_SIGN) |-> dig_cnt_q != '0)
		else $error("digit count empty while emitting");

	// the first digit after zero skipping is nonzero unless it is the only one
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sidc_pkg::ST_SKIP && state_d != sidc_pkg::ST_SKIP)
		|-> (top_digit != '0 || dig_cnt_q == sidc_pkg::DIG_CNT_W'(1)))
		else $error("leading zero left after skip");

	// input and output sides are never open in the same cycle
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("accepting a value while characters are pending");

endmodule

// ===== verif/signed_int_to_decimal_chars_test.sv =====
// Self-checking bench for signed_int_to_decimal_chars: random and corner values in,
// decimal ASCII characters out, checked against a local digit predictor.
// Depends on sidc_pkg and the block's RTL only.
module signed_int_to_decimal_chars_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RADIX          = 10;
	localparam int RANDOM_VALUES  = 420;
	localparam int IDLE_PERCENT   = 28;
	localparam int DRAIN_CYCLES   = 80;
	// Cycle window in which neither side idles.
	localparam int CALM_FIRST     = 4000;
	localparam int CALM_LAST      = 9000;
	localparam int REPORT_LIMIT   = 10;

	// One expected character beat on the output side.
	typedef struct packed {
		logic [sidc_pkg::CHAR_W-1:0] code;
		logic                        last;
	} char_beat_t;

	logic                          clk;
	logic                          arst_n;
	logic [sidc_pkg::VALUE_W-1:0]  s_tdata;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [sidc_pkg::CHAR_W-1:0]   m_tdata;
	logic                          m_tlast;
	logic                          m_tvalid;
	logic                          m_tready;

	logic [sidc_pkg::VALUE_W-1:0]  values_to_send [$];
	char_beat_t                    expected_chars [$];
	int unsigned                   mismatch_count = 0;
	int unsigned                   cycle_count = 0;

	signed_int_to_decimal_chars u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),   // value (bits 31:0, signed)
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),   // char_code (bits 7:0)
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Decide whether a side sits out this cycle; never inside the calm window.
	function automatic logic take_break();
		if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST)
			return 1'b0;
		return $urandom_range(99) < IDLE_PERCENT;
	endfunction

	// Spell one value as decimal text and queue the characters it must produce:
	// optional minus sign, then digits most significant first, last one marked.
	// The magnitude is the unsigned two's complement negation, so the most
	// negative value spells out its full ten digits.
	function automatic void spell_decimal(logic [sidc_pkg::VALUE_W-1:0] value);
		logic [sidc_pkg::VALUE_W-1:0] magnitude;
		logic [sidc_pkg::CHAR_W-1:0]  digits [$];
		char_beat_t                   beat;
		magnitude = value[sidc_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
		// Peel digits from the bottom; zero still yields a single '0'.
		do begin
			digits.push_front(sidc_pkg::DIGIT_BASE +
				sidc_pkg::CHAR_W'(magnitude % RADIX));
			magnitude = magnitude / RADIX;
		end while (magnitude != 0);
		if (value[sidc_pkg::VALUE_W-1]) begin
			beat.code = sidc_pkg::MINUS_CODE;
			beat.last = 1'b0;
			expected_chars.push_back(beat);
		end
		foreach (digits[i]) begin
			beat.code = digits[i];
			beat.last = (i == digits.size() - 1);
			expected_chars.push_back(beat);
		end
	endfunction

	// Random value: mostly a chosen digit count with random sign, so every text
	// length from one to eleven characters shows up often; the rest raw 32-bit
	// words (every input bit toggles) and values hugging zero.
	function automatic logic [sidc_pkg::VALUE_W-1:0] draw_value();
		longint low;
		longint high;
		longint magnitude;
		logic   negative;
		int     num_digits;
		int     pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			num_digits = $urandom_range(sidc_pkg::NUM_DIGITS, 1);
			negative = 1'($urandom_range(1));
			low = 1;
			for (int k = 1; k < num_digits; k++)
				low = low * RADIX;
			high = low * RADIX - 1;
			if (num_digits == 1)
				low = 0;
			// Clip the widest range to what 32 bits can hold for this sign.
			if (negative && high > 64'd2147483648)
				high = 64'd2147483648;
			if (!negative && high > 64'd2147483647)
				high = 64'd2147483647;
			magnitude = $urandom_range(32'(high), 32'(low));
			return sidc_pkg::VALUE_W'(negative ? -magnitude : magnitude);
		end
		if (pick < 85)
			return $urandom();
		return sidc_pkg::VALUE_W'($signed($urandom_range(40)) - 20);
	endfunction

	// Count a mismatch; print only the first few.
	task automatic flag_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] %s", $realtime, what);
	endtask

	// Input driver: hold a beat until it is taken, then advance to the next
	// pending value or idle at random. Each accepted beat feeds the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				spell_decimal(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (values_to_send.size() != 0 && !take_break()) begin
					s_tdata  <= values_to_send.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare every accepted character beat with the oldest
	// expectation, field by field, and stall the output side at random.
	always @(posedge clk or negedge arst_n) begin
		char_beat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					flag_mismatch($sformatf("unexpected char 0x%02h last=%0b",
						m_tdata, m_tlast));
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.code)
						flag_mismatch($sformatf("char_code: expected 0x%02h, got 0x%02h",
							want.code, m_tdata));
					if (m_tlast !== want.last)
						flag_mismatch($sformatf("last: expected %0b, got %0b",
							want.last, m_tlast));
				end
			end
			m_tready <= !take_break();
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [sidc_pkg::VALUE_W-1:0] corner_values [22];
		corner_values = '{
			32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
			32'd99, 32'd100, -32'sd100, 32'd12345, -32'sd67890,
			32'd999999999, 32'd1000000000, -32'sd1000000000,
			32'd2147483647, -32'sd2147483647, 32'h8000_0000,
			32'd1234567890, -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA
		};
		// Directed part first: zero, one-digit values, the digit boundaries 9/10,
		// 99/100 and 999999999/1000000000, both extremes including the most negative value.
		foreach (corner_values[i])
			values_to_send.push_back(corner_values[i]);
		repeat (RANDOM_VALUES)
			values_to_send.push_back(draw_value());

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all values taken, then all characters back, then a quiet tail
		// to catch any stray beat.
		while (values_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_chars.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
